/* hdl/pdsl_pkg.sv */
`timescale 1ns / 1ps
// pdsl_pkg: shared types, register indexes, reset values and microcode ROM
// for the PID drive with slew limit. No dependencies.
package pdsl_pkg;

	localparam int POWER_FRAC_BITS_DEF = 14;
	localparam int UPC_W               = 5;
	localparam int CFG_IDX_W           = 3;
	localparam int CFG_DATA_W          = 32;

	localparam logic [31:0] TARGET_RST = 32'd0;
	localparam logic [31:0] SCALE_RST  = 32'd501849;
	localparam logic [31:0] GAIN_P_RST = 32'd14261;
	localparam logic [31:0] GAIN_I_RST = 32'd0;
	localparam logic [31:0] GAIN_D_RST = 32'd0;
	localparam logic [14:0] SLEW_RST   = 15'd1638;
	localparam logic [30:0] BAND_RST   = 31'd65536;
	localparam logic [30:0] WINDOW_RST = 31'd13107200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET = 3'd0,
		REG_SCALE  = 3'd1,
		REG_GAIN_P = 3'd2,
		REG_GAIN_I = 3'd3,
		REG_GAIN_D = 3'd4,
		REG_SLEW   = 3'd5,
		REG_BAND   = 3'd6,
		REG_WINDOW = 3'd7
	} reg_idx_t;

	// datapath operation per microstep
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ERR,
		OP_PREP,
		OP_LOAD_I,
		OP_LOAD_D,
		OP_ACC_LO,
		OP_ACC_HI,
		OP_TERM,
		OP_CLAMP,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_DIST,
		MUL_LO,
		MUL_HI
	} mul_t;

	typedef enum logic [1:0] {
		G_P,
		G_I,
		G_D
	} gain_sel_t;

	typedef struct packed {
		op_t              op;
		mul_t             mul;
		gain_sel_t        gsel;
		logic             jz;      // jump to target when selected gain is zero
		logic [UPC_W-1:0] target;
	} ctl_word_t;

	typedef struct packed {
		logic start;
		logic gain_zero;
		logic stall;
	} seq_status_t;

	localparam logic [UPC_W-1:0] STEP_I   = 5'd7;
	localparam logic [UPC_W-1:0] STEP_D   = 5'd12;
	localparam logic [UPC_W-1:0] STEP_END = 5'd17;

	function automatic ctl_word_t cw(input op_t op, input mul_t mul, input gain_sel_t g,
			input logic jz, input logic [UPC_W-1:0] tgt);
		ctl_word_t w;
		w.op     = op;
		w.mul    = mul;
		w.gsel   = g;
		w.jz     = jz;
		w.target = tgt;
		return w;
	endfunction

	// Microprogram: distance, error, then P, I, D terms on the shared
	// multiplier (low half, high half, accumulate, scale), clamp, slew.
	function automatic ctl_word_t ucode(input logic [UPC_W-1:0] upc);
		ctl_word_t w;
		w = cw(OP_NOP, MUL_NONE, G_P, 1'b0, '0);
		case (upc)
			5'd0:  w = cw(OP_NOP,    MUL_DIST, G_P, 1'b0, '0);
			5'd1:  w = cw(OP_ERR,    MUL_NONE, G_P, 1'b0, '0);
			5'd2:  w = cw(OP_PREP,   MUL_NONE, G_P, 1'b0, '0);
			5'd3:  w = cw(OP_NOP,    MUL_LO,   G_P, 1'b1, STEP_I);
			5'd4:  w = cw(OP_ACC_LO, MUL_HI,   G_P, 1'b0, '0);
			5'd5:  w = cw(OP_ACC_HI, MUL_NONE, G_P, 1'b0, '0);
			5'd6:  w = cw(OP_TERM,   MUL_NONE, G_P, 1'b0, '0);
			5'd7:  w = cw(OP_LOAD_I, MUL_NONE, G_I, 1'b0, '0);
			5'd8:  w = cw(OP_NOP,    MUL_LO,   G_I, 1'b1, STEP_D);
			5'd9:  w = cw(OP_ACC_LO, MUL_HI,   G_I, 1'b0, '0);
			5'd10: w = cw(OP_ACC_HI, MUL_NONE, G_I, 1'b0, '0);
			5'd11: w = cw(OP_TERM,   MUL_NONE, G_I, 1'b0, '0);
			5'd12: w = cw(OP_LOAD_D, MUL_NONE, G_D, 1'b0, '0);
			5'd13: w = cw(OP_NOP,    MUL_LO,   G_D, 1'b1, STEP_END);
			5'd14: w = cw(OP_ACC_LO, MUL_HI,   G_D, 1'b0, '0);
			5'd15: w = cw(OP_ACC_HI, MUL_NONE, G_D, 1'b0, '0);
			5'd16: w = cw(OP_TERM,   MUL_NONE, G_D, 1'b0, '0);
			5'd17: w = cw(OP_CLAMP,  MUL_NONE, G_P, 1'b0, '0);
			5'd18: w = cw(OP_FINISH, MUL_NONE, G_P, 1'b0, '0);
			default: w = cw(OP_NOP, MUL_NONE, G_P, 1'b0, '0);
		endcase
		return w;
	endfunction

endpackage

/* hdl/pid_drive_with_slew_limit_unit.sv */
`timescale 1ns / 1ps
// Distance PID drive with output clamp and slew limit: top level with the
// datapath and config registers. Depends on pdsl_pkg and pdsl_seq.
//
// One request in (left and right wheel positions) gives one result out (power,
// error, done flag). The block works on one request at a time. The step
// sequence is set by the microprogram: every term goes through the single
// 33x33 multiplier as a low and a high partial product, and a zero gain
// skips its term. The next request is taken as soon as the result sits in
// the output register; a result not yet taken holds the last step.
// Config writes are only valid while idle.
module pid_drive_with_slew_limit_unit import pdsl_pkg::*; #(
	parameter int POWER_FRAC_BITS = POWER_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [63:0]           s_axis_tdata,   // left_position, right_position
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [47:0]           m_axis_tdata,   // drive_power, position_error
	output logic [0:0]            m_axis_tuser,   // move_done
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SHIFT = 40 - POWER_FRAC_BITS;
	localparam int CAPB  = 60 + SHIFT;
	localparam int LPW   = POWER_FRAC_BITS + 2;
	localparam int SLW   = ((LPW > 16) ? LPW : 16) + 2;
	localparam logic signed [63:0] ONE  = 64'sd1 <<< POWER_FRAC_BITS;
	localparam logic [60:0]        TCAP = 61'd1 << 60;

	// config
	logic signed [31:0] target_q;
	logic [31:0]        scale_q, gain_p_q, gain_i_q, gain_d_q;
	logic [14:0]        slew_q;
	logic [30:0]        band_q, window_q;

	// loop state
	logic signed [47:0]     error_sum_q;
	logic signed [31:0]     last_error_q;
	logic signed [LPW-1:0]  last_power_q;

	// working registers
	logic signed [31:0]     avg_q;
	logic signed [65:0]     prod_q;
	logic signed [31:0]     err_q;
	logic signed [47:0]     nsum_q;
	logic signed [32:0]     diff_q;
	logic [47:0]            mag_q;
	logic                   neg_q;
	logic                   done_q;
	logic [79:0]            acc_q;
	logic signed [63:0]     psum_q;
	logic signed [LPW-1:0]  pwr_q;
	logic                   out_valid_q;
	logic [47:0]            out_data_q;
	logic                   out_done_q;

	ctl_word_t   ctl;
	seq_status_t status;
	logic        busy, accept, stall, commit;

	function automatic logic [47:0] abs48(input logic [47:0] v);
		return v[47] ? (~v + 48'd1) : v;
	endfunction

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy;
	assign stall         = out_valid_q && !m_axis_tready;
	assign commit        = (ctl.op == OP_FINISH) && !stall;

	logic [31:0] gain_w;
	always_comb begin
		case (ctl.gsel)
			G_P:     gain_w = gain_p_q;
			G_I:     gain_w = gain_i_q;
			G_D:     gain_w = gain_d_q;
			default: gain_w = '0;
		endcase
	end

	assign status.start     = accept;
	assign status.gain_zero = (gain_w == '0);
	assign status.stall     = stall;

	pdsl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl),
		.busy   (busy)
	);

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_w;
	always_comb begin
		case (ctl.mul)
			MUL_DIST: begin
				mul_a = {avg_q[31], avg_q};
				mul_b = {1'b0, scale_q};
			end
			MUL_LO: begin
				mul_a = {1'b0, mag_q[31:0]};
				mul_b = {1'b0, gain_w};
			end
			MUL_HI: begin
				mul_a = {17'd0, mag_q[47:32]};
				mul_b = {1'b0, gain_w};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_w = mul_a * mul_b;
	end

	// input average, floor of half the 33-bit sum
	logic [32:0] in_sum;
	assign in_sum = {s_axis_tdata[31], s_axis_tdata[31:0]}
		+ {s_axis_tdata[63], s_axis_tdata[63:32]};

	// error from distance product, saturated to 32 bits
	logic [49:0]        dist_w;
	logic [50:0]        err_w;
	logic signed [31:0] err_sat;
	always_comb begin
		dist_w = prod_q[65:16];
		err_w  = {{19{target_q[31]}}, target_q} - {dist_w[49], dist_w};
		if (err_w[50:31] == {20{err_w[50]}}) begin
			err_sat = err_w[31:0];
		end else begin
			err_sat = err_w[50] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	// integral update, derivative and done test
	logic [47:0]        es_mag, err_mag;
	logic [48:0]        ns_w;
	logic signed [47:0] ns_sat;
	logic [32:0]        diff_w;
	always_comb begin
		es_mag  = abs48(error_sum_q);
		err_mag = abs48({{16{err_q[31]}}, err_q});
		ns_w    = {error_sum_q[47], error_sum_q} + {{17{err_q[31]}}, err_q};
		if (ns_w[48] == ns_w[47]) begin
			ns_sat = ns_w[47:0];
		end else begin
			ns_sat = ns_w[48] ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
		end
		diff_w = {err_q[31], err_q} - {last_error_q[31], last_error_q};
	end

	// term: floor of signed product over 2^SHIFT, magnitude capped at 2^60
	logic [79:0] qsh;
	logic        rem_nz, cap_hit;
	logic [60:0] qm;
	logic [63:0] term_w;
	always_comb begin
		qsh     = acc_q >> SHIFT;
		rem_nz  = (acc_q << (80 - SHIFT)) != '0;
		cap_hit = (acc_q >> CAPB) != '0;
		qm      = cap_hit ? TCAP : (qsh[60:0] + {60'd0, neg_q && rem_nz});
		term_w  = {3'd0, qm};
		if (neg_q) begin
			term_w = ~term_w + 64'd1;
		end
	end

	// clamp to +/- full scale
	logic signed [63:0] clamp_w;
	always_comb begin
		if (psum_q > ONE) begin
			clamp_w = ONE;
		end else if (psum_q < -ONE) begin
			clamp_w = -ONE;
		end else begin
			clamp_w = psum_q;
		end
	end

	// slew limit around the previous power
	logic signed [SLW-1:0] lp_w, hi_w, lo_w, pw_w;
	always_comb begin
		lp_w = SLW'(last_power_q);
		hi_w = lp_w + $signed({{(SLW-15){1'b0}}, slew_q});
		lo_w = lp_w - $signed({{(SLW-15){1'b0}}, slew_q});
		pw_w = SLW'(pwr_q);
		if (pw_w > hi_w) begin
			pw_w = hi_w;
		end
		if (pw_w < lo_w) begin
			pw_w = lo_w;
		end
	end

	// config registers and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= TARGET_RST;
			scale_q      <= SCALE_RST;
			gain_p_q     <= GAIN_P_RST;
			gain_i_q     <= GAIN_I_RST;
			gain_d_q     <= GAIN_D_RST;
			slew_q       <= SLEW_RST;
			band_q       <= BAND_RST;
			window_q     <= WINDOW_RST;
			error_sum_q  <= '0;
			last_error_q <= '0;
			last_power_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_TARGET: target_q <= cfg_data[31:0];
					REG_SCALE:  scale_q  <= cfg_data[31:0];
					REG_GAIN_P: gain_p_q <= cfg_data[31:0];
					REG_GAIN_I: gain_i_q <= cfg_data[31:0];
					REG_GAIN_D: gain_d_q <= cfg_data[31:0];
					REG_SLEW:   slew_q   <= cfg_data[14:0];
					REG_BAND:   band_q   <= cfg_data[30:0];
					REG_WINDOW: window_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (!done_q) begin
					error_sum_q  <= nsum_q;
					last_error_q <= err_q;
					last_power_q <= pw_w[LPW-1:0];
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			avg_q <= in_sum[32:1];
		end
		if (ctl.mul != MUL_NONE) begin
			prod_q <= prod_w;
		end
		case (ctl.op)
			OP_ERR: begin
				err_q <= err_sat;
			end
			OP_PREP: begin
				nsum_q <= (es_mag <= {17'd0, window_q}) ? ns_sat : error_sum_q;
				diff_q <= diff_w;
				done_q <= err_mag < {17'd0, band_q};
				mag_q  <= err_mag;
				neg_q  <= err_q[31];
				psum_q <= '0;
			end
			OP_LOAD_I: begin
				mag_q <= abs48(nsum_q);
				neg_q <= nsum_q[47];
			end
			OP_LOAD_D: begin
				mag_q <= abs48({{15{diff_q[32]}}, diff_q});
				neg_q <= diff_q[32];
			end
			OP_ACC_LO: begin
				acc_q <= {16'd0, prod_q[63:0]};
			end
			OP_ACC_HI: begin
				acc_q <= acc_q + {prod_q[47:0], 32'd0};
			end
			OP_TERM: begin
				psum_q <= psum_q + term_w;
			end
			OP_CLAMP: begin
				pwr_q <= clamp_w[LPW-1:0];
			end
			OP_FINISH: begin
				if (commit) begin
					out_data_q <= {err_q, pw_w[15:0]};
					out_done_q <= done_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_done_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request accepted while busy");
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctl.op == OP_FINISH))
		else $error("result raised outside the finish step");
	a_done_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && done_q) |=> ($stable(error_sum_q) && $stable(last_error_q)
			&& $stable(last_power_q)))
		else $error("loop state changed on a done sample");
	a_power_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (pw_w <= SLW'(ONE) && pw_w >= -SLW'(ONE)))
		else $error("drive power outside full scale");

endmodule

/* hdl/pdsl_seq.sv */
`timescale 1ns / 1ps
// pdsl_seq: step counter and microcode ROM for the PID drive sequencer.
// Depends on pdsl_pkg (control word, ROM function).
module pdsl_seq import pdsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ctl_word_t   ctl,
	output logic        busy
);

	logic [UPC_W-1:0] upc_q;
	logic             busy_q;
	ctl_word_t        rom_w;

	assign rom_w = ucode(upc_q);
	assign ctl   = busy_q ? rom_w : cw(OP_NOP, MUL_NONE, G_P, 1'b0, '0);
	assign busy  = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= '0;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (status.start) begin
				busy_q <= 1'b1;
				upc_q  <= '0;
			end
		end else if (rom_w.op == OP_FINISH) begin
			// hold on the last step until the output slot frees
			if (!status.stall) begin
				busy_q <= 1'b0;
			end
		end else if (rom_w.jz && status.gain_zero) begin
			upc_q <= rom_w.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && status.start) |=> (busy_q && upc_q == '0))
		else $error("sequencer did not start at step zero");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && rom_w.op == OP_FINISH && !status.stall) |=> !busy_q)
		else $error("sequencer did not return to idle after finish");
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && rom_w.jz && status.gain_zero) |=> (upc_q == $past(rom_w.target)))
		else $error("zero-gain skip missed its target");

endmodule
